[hdl/efbd_pkg.sv]
// Shared types and constants for the escaped frame beacon deframer.
package efbd_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_HEAD   = 3'd0;
    localparam logic [2:0] CFG_TAIL   = 3'd1;
    localparam logic [2:0] CFG_ESCAPE = 3'd2;
    localparam logic [2:0] CFG_LENGTH = 3'd3;
    localparam logic [2:0] CFG_RSSI   = 3'd4;
    localparam logic [2:0] CFG_UUID   = 3'd5;

    // Register reset values
    localparam logic [7:0] HEAD_RST   = 8'hAA;
    localparam logic [7:0] TAIL_RST   = 8'h55;
    localparam logic [7:0] ESCAPE_RST = 8'hA5;
    localparam logic [5:0] LENGTH_RST = 6'd29;
    localparam logic [4:0] RSSI_RST   = 5'd6;
    localparam logic [4:0] UUID_RST   = 5'd7;

    // Input kind codes
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_REARM = 1'b1;

    // Wide enough to hold any store index, count or depth (depth up to 256)
    localparam int WIDE_W = 9;

    // Identifier bytes per frame, and the read step that fetches the last one
    localparam int UUID_BYTES = 16;
    localparam logic [4:0] STEP_LAST = 5'd16;
    localparam logic [4:0] STEP_RSSI = 5'd0;

    // Bus widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 80;

    // Frame command handed from the front to the back
    typedef struct packed {
        logic [4:0] rssi_pos;
        logic [4:0] uuid_pos;
    } t_frame_cmd;

    // Back sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_SEND0 = 5'b01000,
        ST_SEND1 = 5'b10000
    } t_back_state;

endpackage

[hdl/efbd_front.sv]
// Front end: classifies received bytes, tracks frame state and writes payload bytes.
module efbd_front import efbd_pkg::*; #(
    parameter int BUFFER_DEPTH = 32,
    parameter int AW = $clog2(BUFFER_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_kind,
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_head_byte,
    input  logic [7:0]       i_tail_byte,
    input  logic [7:0]       i_escape_byte,
    input  logic [5:0]       i_frame_length,
    input  logic [4:0]       i_rssi_position,
    input  logic [4:0]       i_uuid_position,
    input  logic             i_q_full,
    output logic             o_push,
    output t_frame_cmd       o_cmd,
    input  logic             i_done,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output logic [7:0]       o_wr_data
);

    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic          r_head_seen, n_head_seen;
    logic          r_escape, n_escape;
    logic [7:0]    r_sum, n_sum;
    logic [CW-1:0] r_count, n_count;
    logic          r_locked, n_locked;
    logic          r_wait, n_wait;
    logic          accept;
    logic          store_room;
    logic          frame_good;

    assign o_ready    = !r_wait && !i_q_full;
    assign accept     = i_valid && o_ready;
    assign store_room = r_count < CW'(BUFFER_DEPTH);
    assign frame_good = r_head_seen && (r_sum == 8'd0)
                        && (WIDE_W'(r_count) == WIDE_W'(i_frame_length));

    assign o_cmd.rssi_pos = i_rssi_position;
    assign o_cmd.uuid_pos = i_uuid_position;
    assign o_wr_data      = i_byte;
    assign o_wr_addr      = r_count[AW-1:0];

    // Classify the item and work out the next frame state
    always_comb begin
        n_head_seen = r_head_seen;
        n_escape    = r_escape;
        n_sum       = r_sum;
        n_count     = r_count;
        n_locked    = r_locked;
        n_wait      = r_wait;
        o_push      = 1'b0;
        o_wr_en     = 1'b0;
        if (i_done) begin
            n_wait = 1'b0;
        end
        if (accept) begin
            if (i_kind == KIND_REARM) begin
                n_head_seen = 1'b0;
                n_escape    = 1'b0;
                n_sum       = 8'd0;
                n_count     = '0;
                n_locked    = 1'b0;
            end else if (!r_locked) begin
                priority if (r_escape) begin
                    n_escape = 1'b0;
                    n_sum    = r_sum + i_byte;
                    if (store_room) begin
                        o_wr_en = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end else if (i_byte == i_escape_byte) begin
                    n_escape = 1'b1;
                end else if (i_byte == i_head_byte) begin
                    n_sum       = 8'd0;
                    n_count     = '0;
                    n_head_seen = 1'b1;
                    n_escape    = 1'b0;
                end else if (i_byte == i_tail_byte) begin
                    if (frame_good) begin
                        o_push   = 1'b1;
                        n_locked = 1'b1;
                        n_wait   = 1'b1;
                    end else begin
                        n_head_seen = 1'b0;
                        n_escape    = 1'b0;
                        n_sum       = 8'd0;
                        n_count     = '0;
                    end
                end else if (r_head_seen) begin
                    n_sum = r_sum + i_byte;
                    if (store_room) begin
                        o_wr_en = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end else begin
                    // Drop plain bytes outside a frame
                end
            end
        end
    end

    // Hold frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_seen <= 1'b0;
            r_escape    <= 1'b0;
            r_sum       <= 8'd0;
            r_count     <= '0;
            r_locked    <= 1'b0;
            r_wait      <= 1'b0;
        end else begin
            r_head_seen <= n_head_seen;
            r_escape    <= n_escape;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_locked    <= n_locked;
            r_wait      <= n_wait;
        end
    end

    // A good tail stops intake until the back has delivered both results
    a_push_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> !o_ready)
        else $error("front accepts items right after a frame push");

    // The store count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(BUFFER_DEPTH))
        else $error("payload count beyond store depth");

    // A push only comes from a locking tail
    a_push_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_locked)
        else $error("frame pushed without lock");

endmodule

[hdl/efbd_queue.sv]
// Two-entry command queue between the front and the back.
module efbd_queue import efbd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_cmd i_cmd,
    output logic       o_full,
    input  logic       i_pop,
    output t_frame_cmd o_cmd,
    output logic       o_empty
);

    t_frame_cmd r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;

    assign o_full  = r_fill == 2'd2;
    assign o_empty = r_fill == 2'd0;
    assign o_cmd   = r_entry[r_rd_ptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_fill <= r_fill + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into a full command queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from an empty command queue");

endmodule

[hdl/efbd_back.sv]
// Back end: payload store, identifier gather sequencer and result output register.
module efbd_back import efbd_pkg::*; #(
    parameter int BUFFER_DEPTH = 32,
    parameter int AW = $clog2(BUFFER_DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [7:0]           i_wr_data,
    input  logic                 i_q_empty,
    input  t_frame_cmd           i_cmd,
    output logic                 o_pop,
    output logic                 o_done,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [63:0]          o_uuid_part,
    output logic                 o_part_index,
    output logic [8:0]           o_rssi,
    output logic                 o_last
);

    logic [7:0]        r_mem [BUFFER_DEPTH];
    logic              r_vld [BUFFER_DEPTH];
    t_back_state       r_state, n_state;
    t_frame_cmd        r_cmd;
    logic [4:0]        r_step;
    logic              r_rd_en;
    logic [4:0]        r_rd_step;
    logic              r_rd_ok;
    logic [7:0]        r_rd_data;
    logic [7:0]        r_rssi_byte;
    logic [8*UUID_BYTES-1:0] r_uuid;
    logic [WIDE_W-1:0] rd_idx;
    logic              rd_in_range;
    logic              rd_issue;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_byte;

    // Read index: signal byte first, then the identifier bytes in order
    assign rd_idx      = (r_step == STEP_RSSI) ? WIDE_W'(r_cmd.rssi_pos)
                         : WIDE_W'(r_cmd.uuid_pos) + WIDE_W'(r_step - 5'd1);
    assign rd_in_range = rd_idx < WIDE_W'(BUFFER_DEPTH);
    assign rd_addr     = rd_idx[AW-1:0];
    assign rd_issue    = r_state == ST_READ;
    assign rd_byte     = r_rd_ok ? r_rd_data : 8'h00;

    // Payload store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Entry valid bits: an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Sequence the gather and the two results
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        o_done  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_step == STEP_LAST) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (r_rd_en && r_rd_step == STEP_LAST) begin
                    n_state = ST_SEND0;
                end
            end
            ST_SEND0: begin
                if (i_ready) begin
                    n_state = ST_SEND1;
                end
            end
            ST_SEND1: begin
                if (i_ready) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= STEP_RSSI;
            r_rd_en   <= 1'b0;
            r_rd_step <= STEP_RSSI;
            r_rd_ok   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_en   <= rd_issue;
            r_rd_step <= r_step;
            r_rd_ok   <= rd_issue && rd_in_range && r_vld[rd_addr];
            if (rd_issue) begin
                r_step <= r_step + 5'd1;
            end else begin
                r_step <= STEP_RSSI;
            end
        end
    end

    // Capture the command and collect returned bytes, first byte most significant
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_rd_en) begin
            if (r_rd_step == STEP_RSSI) begin
                r_rssi_byte <= rd_byte;
            end else begin
                r_uuid <= {r_uuid[8*UUID_BYTES-9:0], rd_byte};
            end
        end
    end

    assign o_valid      = (r_state == ST_SEND0) || (r_state == ST_SEND1);
    assign o_part_index = r_state == ST_SEND1;
    assign o_last       = r_state == ST_SEND1;
    assign o_uuid_part  = (r_state == ST_SEND1) ? r_uuid[63:0]
                          : r_uuid[8*UUID_BYTES-1:64];
    assign o_rssi       = {1'b1, r_rssi_byte};

    // The store must not change while a frame is being gathered
    a_no_write_in_gather: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> (r_state == ST_IDLE))
        else $error("payload store written during gather");

    // The second result follows the first once it is taken
    a_send_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEND0 && i_ready) |=> (r_state == ST_SEND1))
        else $error("second result did not follow the first");

    // Done is signalled only as the final result leaves
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_valid && i_ready && o_last))
        else $error("done raised without final result handshake");

endmodule

[hdl/escaped_frame_beacon_deframer.sv]
// Top level of the escaped frame beacon deframer: configuration registers and wiring.
//
// Received bytes enter on the slave stream one per cycle and are classified at once;
// payload bytes land in an on-chip store of BUFFER_DEPTH entries. When a tail closes a
// good frame (head seen, zero modulo-256 sum, stored count equal to frame_length), a
// sequencer reads the signal byte and the sixteen identifier bytes from the store, one
// per cycle through its single read port, and presents two results: bytes 0..7 then
// bytes 8..15, each with the signal strength as byte minus 256, the second with tlast.
// A good tail's command passes through the two-entry command queue; the sequencer pops
// it, reads the store, and presents the first result once the last byte has returned.
// Input stays stalled until the second result is taken. After a good frame, received
// bytes are ignored until a rearm item (tuser high). The store clears to zero at reset
// through per-entry valid bits, with no clearing pass; a rearm keeps its contents.
module escaped_frame_beacon_deframer import efbd_pkg::*; #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [7:0] data_byte
    input  logic                 s_axis_tuser,  // [0] kind
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // [63:0] uuid_part, [72:64] rssi, zeros above
    output logic                 m_axis_tuser,  // [0] part_index
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_wr_en,
    input  logic [2:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [7:0]    r_head_byte;
    logic [7:0]    r_tail_byte;
    logic [7:0]    r_escape_byte;
    logic [5:0]    r_frame_length;
    logic [4:0]    r_rssi_position;
    logic [4:0]    r_uuid_position;

    logic          q_push, q_pop, q_full, q_empty;
    t_frame_cmd    push_cmd, pop_cmd;
    logic          back_done;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [63:0]   uuid_part;
    logic [8:0]    rssi;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_byte     <= HEAD_RST;
            r_tail_byte     <= TAIL_RST;
            r_escape_byte   <= ESCAPE_RST;
            r_frame_length  <= LENGTH_RST;
            r_rssi_position <= RSSI_RST;
            r_uuid_position <= UUID_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_HEAD:   r_head_byte     <= i_cfg_data;
                CFG_TAIL:   r_tail_byte     <= i_cfg_data;
                CFG_ESCAPE: r_escape_byte   <= i_cfg_data;
                CFG_LENGTH: r_frame_length  <= i_cfg_data[5:0];
                CFG_RSSI:   r_rssi_position <= i_cfg_data[4:0];
                CFG_UUID:   r_uuid_position <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    efbd_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_kind          (s_axis_tuser),
        .i_byte          (s_axis_tdata[7:0]),
        .i_head_byte     (r_head_byte),
        .i_tail_byte     (r_tail_byte),
        .i_escape_byte   (r_escape_byte),
        .i_frame_length  (r_frame_length),
        .i_rssi_position (r_rssi_position),
        .i_uuid_position (r_uuid_position),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_cmd           (push_cmd),
        .i_done          (back_done),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data)
    );

    efbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (pop_cmd),
        .o_empty (q_empty)
    );

    efbd_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .i_q_empty    (q_empty),
        .i_cmd        (pop_cmd),
        .o_pop        (q_pop),
        .o_done       (back_done),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_uuid_part  (uuid_part),
        .o_part_index (m_axis_tuser),
        .o_rssi       (rssi),
        .o_last       (m_axis_tlast)
    );

    // Pack the result item
    assign m_axis_tdata = {(M_TDATA_W - 73)'(0), rssi, uuid_part};

endmodule

[tb/sv/tb_escaped_frame_beacon_deframer.sv]
// Self-checking testbench for the escaped frame beacon deframer, with its own frame predictor.
module tb_escaped_frame_beacon_deframer;
    import efbd_pkg::*;

    localparam int STORE_DEPTH    = 32;
    localparam int SETTLE_CYCLES  = 32;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1400;

    // One beacon result as it leaves the block
    typedef struct packed {
        logic [63:0] uuid_part;
        logic        part_index;
        logic [8:0]  rssi;
        logic        last;
    } beacon_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;    // [7:0] data_byte
    logic                 s_axis_tuser = 1'b0;  // [0] kind
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // [63:0] uuid_part, [72:64] rssi
    logic                 m_axis_tuser;         // [0] part_index
    logic                 m_axis_tlast;
    logic                 i_cfg_wr_en = 1'b0;
    logic [2:0]           i_cfg_index = '0;
    logic [7:0]           i_cfg_data = '0;

    escaped_frame_beacon_deframer #(
        .BUFFER_DEPTH (STORE_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Predictor copy of the registers
    logic [7:0] head_code;
    logic [7:0] tail_code;
    logic [7:0] esc_code;
    logic [5:0] need_len;
    logic [4:0] sig_pos;
    logic [4:0] id_pos;

    // Predictor copy of the deframing state
    bit          in_frame;
    bit          esc_armed;
    bit          locked;
    logic [7:0]  sum8;
    int unsigned stored;
    logic [7:0]  store_mem [STORE_DEPTH];

    beacon_t pending_beacons [$];
    int      fail_count = 0;
    int      effective_items = 0;
    int      src_idle_pct = 0;
    int      sink_idle_pct = 0;
    int      quiet_cycles = 0;

    // Predictor -----------------------------------------------------------

    function automatic void reset_deframer();
        head_code = HEAD_RST;
        tail_code = TAIL_RST;
        esc_code  = ESCAPE_RST;
        need_len  = LENGTH_RST;
        sig_pos   = RSSI_RST;
        id_pos    = UUID_RST;
        in_frame  = 1'b0;
        esc_armed = 1'b0;
        locked    = 1'b0;
        sum8      = '0;
        stored    = 0;
        foreach (store_mem[i]) store_mem[i] = '0;
    endfunction

    function automatic void restart_search();
        in_frame  = 1'b0;
        esc_armed = 1'b0;
        sum8      = '0;
        stored    = 0;
    endfunction

    // Sum every payload byte; keep it only while the store has room
    function automatic void store_byte(logic [7:0] b);
        sum8 = sum8 + b;
        if (stored < STORE_DEPTH) begin
            store_mem[stored] = b;
            stored++;
        end
    endfunction

    function automatic logic [7:0] read_mem(int unsigned idx);
        if (idx >= STORE_DEPTH) return 8'h00;
        return store_mem[idx];
    endfunction

    // Eight bytes from the store, the first one most significant
    function automatic logic [63:0] gather_bytes(int unsigned first);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < 8; i++) v = {v[55:0], read_mem(first + i)};
        return v;
    endfunction

    function automatic void write_register(logic [2:0] idx, logic [7:0] d);
        case (idx)
            CFG_HEAD:   head_code = d;
            CFG_TAIL:   tail_code = d;
            CFG_ESCAPE: esc_code  = d;
            CFG_LENGTH: need_len  = d[5:0];
            CFG_RSSI:   sig_pos   = d[4:0];
            CFG_UUID:   id_pos    = d[4:0];
            default: ;
        endcase
    endfunction

    // Advance the predictor by one item; returns 0 when the block ignores it
    function automatic bit advance_deframer(logic k, logic [7:0] b);
        beacon_t    part;
        logic [8:0] sig;
        if (k == KIND_REARM) begin
            restart_search();
            locked = 1'b0;
            return 1'b1;
        end
        if (locked) return 1'b0;
        if (esc_armed) begin
            store_byte(b);
            esc_armed = 1'b0;
            return 1'b1;
        end
        if (b == esc_code) begin
            esc_armed = 1'b1;
            return 1'b1;
        end
        if (b == head_code) begin
            sum8      = '0;
            stored    = 0;
            in_frame  = 1'b1;
            esc_armed = 1'b0;
            return 1'b1;
        end
        if (b == tail_code) begin
            if (in_frame && sum8 == 8'h00 && stored == need_len) begin
                sig = {1'b1, read_mem(sig_pos)};
                part.uuid_part  = gather_bytes(id_pos);
                part.part_index = 1'b0;
                part.rssi       = sig;
                part.last       = 1'b0;
                pending_beacons.push_back(part);
                part.uuid_part  = gather_bytes(int'(id_pos) + 8);
                part.part_index = 1'b1;
                part.last       = 1'b1;
                pending_beacons.push_back(part);
                locked = 1'b1;
            end else begin
                restart_search();
            end
            return 1'b1;
        end
        if (in_frame) store_byte(b);
        return in_frame;
    endfunction

    // Result side ---------------------------------------------------------

    task automatic check_beacon();
        beacon_t exp_b;
        if (pending_beacons.size() == 0) begin
            $error("result with no beacon pending: tdata %h", m_axis_tdata);
            fail_count++;
        end else begin
            exp_b = pending_beacons.pop_front();
            if (m_axis_tdata[63:0] !== exp_b.uuid_part) begin
                $error("uuid_part: expected %h, got %h", exp_b.uuid_part, m_axis_tdata[63:0]);
                fail_count++;
            end
            if (m_axis_tdata[72:64] !== exp_b.rssi) begin
                $error("rssi: expected %h, got %h", exp_b.rssi, m_axis_tdata[72:64]);
                fail_count++;
            end
            if (m_axis_tuser !== exp_b.part_index) begin
                $error("part_index: expected %b, got %b", exp_b.part_index, m_axis_tuser);
                fail_count++;
            end
            if (m_axis_tlast !== exp_b.last) begin
                $error("last: expected %b, got %b", exp_b.last, m_axis_tlast);
                fail_count++;
            end
        end
    endtask

    // Check each accepted result, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_beacon();
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Abort when neither side has moved an item for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL escaped_frame_beacon_deframer");
            $finish;
        end
    end

    // Input side ----------------------------------------------------------

    task automatic send_item(logic k, logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (advance_deframer(k, b)) effective_items++;
    endtask

    // Drop valid and hold until every pending beacon has been taken
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_beacons.size() != 0);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] d);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        write_register(idx, d);
    endtask

    // Reprogram all registers once the block has gone quiet
    task automatic apply_settings(logic [7:0] h, logic [7:0] t, logic [7:0] e,
                                  logic [5:0] len, logic [4:0] rp, logic [4:0] up);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_HEAD, h);
        write_reg(CFG_TAIL, t);
        write_reg(CFG_ESCAPE, e);
        write_reg(CFG_LENGTH, {2'b00, len});
        write_reg(CFG_RSSI, {3'b000, rp});
        write_reg(CFG_UUID, {3'b000, up});
        i_cfg_wr_en <= 1'b0;
    endtask

    // Send a frame of n payload bytes, escaping codes and some plain bytes
    task automatic send_frame(int n, bit zero_sum, bit with_head);
        logic [7:0] payload [$];
        logic [7:0] total;
        logic [7:0] b;
        total = '0;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom);
            if (zero_sum && i == n - 1) b = 8'h00 - total;
            total = total + b;
            payload.push_back(b);
        end
        if (with_head) send_item(KIND_BYTE, head_code);
        foreach (payload[i]) begin
            if (payload[i] == esc_code || payload[i] == head_code ||
                payload[i] == tail_code || $urandom_range(0, 9) == 0) begin
                send_item(KIND_BYTE, esc_code);
            end
            send_item(KIND_BYTE, payload[i]);
        end
        send_item(KIND_BYTE, tail_code);
    endtask

    task automatic pick_codes(output logic [7:0] h, output logic [7:0] t, output logic [7:0] e);
        h = 8'($urandom);
        do t = 8'($urandom); while (t == h);
        do e = 8'($urandom); while (e == h || e == t);
    endtask

    // One random chunk of traffic: mostly well-formed frames, some noise
    task automatic traffic_step();
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            repeat ($urandom_range(1, 4)) begin
                send_item(($urandom_range(0, 9) == 0) ? KIND_REARM : KIND_BYTE, 8'($urandom));
            end
        end else if (sel < 14) begin
            send_frame($urandom_range(0, 8), 1'b1, 1'b0);
        end else begin
            if ($urandom_range(0, 99) < 70) begin
                n = need_len;
            end else if (need_len == 6'd32 && $urandom_range(0, 1) == 1) begin
                n = $urandom_range(33, 36);
            end else begin
                n = $urandom_range(0, 36);
            end
            send_frame(n, $urandom_range(0, 99) < 85, 1'b1);
        end
        // Release the lock, sometimes after bytes that it swallows
        if (locked) begin
            if ($urandom_range(0, 9) < 3) begin
                repeat ($urandom_range(1, 3)) send_item(KIND_BYTE, 8'($urandom));
            end
            send_item(KIND_REARM, 8'($urandom));
        end else if ($urandom_range(0, 99) < 5) begin
            send_item(KIND_REARM, 8'($urandom));
        end
        if ($urandom_range(0, 99) < 4) wait_drained();
    endtask

    // Tests ---------------------------------------------------------------

    // Escaped bytes land in the store even with no head; plain ones do not
    task automatic test_literal_before_head();
        send_item(KIND_BYTE, ESCAPE_RST);
        send_item(KIND_BYTE, 8'h3C);
        send_item(KIND_BYTE, 8'h11);
        send_item(KIND_BYTE, ESCAPE_RST);
        send_item(KIND_BYTE, HEAD_RST);
        send_item(KIND_BYTE, TAIL_RST);
    endtask

    // Good frame under the reset settings, then bytes that the lock swallows
    task automatic test_reset_settings();
        send_frame(int'(LENGTH_RST), 1'b1, 1'b1);
        send_item(KIND_BYTE, HEAD_RST);
        send_item(KIND_BYTE, TAIL_RST);
        send_item(KIND_REARM, 8'h00);
    endtask

    // All-zero and all-one codes, one-byte frame, far store positions
    task automatic test_extreme_codes();
        apply_settings(8'hFF, 8'h00, 8'h01, 6'd1, 5'd31, 5'd16);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, 8'h01);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_REARM, 8'hFF);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, 8'h00);
    endtask

    // Escape wins over head and tail, head wins over tail
    task automatic test_overlapping_codes();
        apply_settings(8'h44, 8'h44, 8'h66, 6'd1, 5'd0, 5'd0);
        send_item(KIND_BYTE, 8'h44);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'h44);
        send_item(KIND_BYTE, 8'h66);
        send_item(KIND_BYTE, 8'h44);
        apply_settings(8'h5A, 8'h77, 8'h5A, 6'd1, 5'd0, 5'd0);
        send_item(KIND_BYTE, 8'h5A);
        send_item(KIND_BYTE, 8'h5A);
        send_item(KIND_BYTE, 8'h77);
    endtask

    // Random traffic over three settings, the first at the given positions
    task automatic test_random_traffic(int src_pct, int snk_pct, logic [5:0] len,
                                       logic [4:0] rp, logic [4:0] up);
        logic [7:0] h;
        logic [7:0] t;
        logic [7:0] e;
        int         start;
        src_idle_pct  = src_pct;
        sink_idle_pct = snk_pct;
        for (int s = 0; s < 3; s++) begin
            pick_codes(h, t, e);
            if (s == 0) begin
                apply_settings(h, t, e, len, rp, up);
            end else begin
                apply_settings(h, t, e, 6'($urandom_range(1, 32)), 5'($urandom_range(0, 31)),
                               5'($urandom_range(0, 16)));
            end
            start = effective_items;
            while (effective_items - start < RANDOM_ITEMS / 9) traffic_step();
        end
    endtask

    initial begin
        reset_deframer();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_literal_before_head();
        test_reset_settings();
        test_extreme_codes();
        test_overlapping_codes();
        test_random_traffic(18, 51, 6'd32, 5'd31, 5'd16);
        test_random_traffic(51, 18, 6'd1, 5'd0, 5'd0);
        test_random_traffic(0, 0, 6'($urandom_range(1, 32)), 5'($urandom_range(0, 31)),
                            5'($urandom_range(0, 16)));

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_beacons.size() != 0) begin
            $error("beacons never delivered: %0d", pending_beacons.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASS escaped_frame_beacon_deframer");
        end else begin
            $display("FAIL escaped_frame_beacon_deframer");
        end
        $finish;
    end

endmodule
